FILE: src/segment_address_translation_core_macros.svh
// ----------------------------------------------------------------------------
// Segment address translation core: assertion macros
// Shorthand for the concurrent checks on the core's ports.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_ADDRESS_TRANSLATION_CORE_MACROS_SVH
`define SEGMENT_ADDRESS_TRANSLATION_CORE_MACROS_SVH

// Same-cycle implication, off while in reset
`define SAT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset
`define SAT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold on the cycle after a reset cycle
`define SAT_ASSERT_RST(lbl, cons, msg) \
  lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

FILE: src/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Widths, codes, field positions and shared types of the segment
// address translation core.
// ----------------------------------------------------------------------------
`default_nettype none

package sat_pkg;

  localparam int ADDR_W           = 64;
  localparam int SLOT_W           = 3;
  localparam int OP_W             = 2;
  localparam int CNT_W            = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int MAX_SEGMENTS_DEF = 8;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
  localparam logic [OP_W-1:0] OP_TO_FILE = 2'd1;
  localparam logic [OP_W-1:0] OP_TO_VIRT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ELF_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD_BIAS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT = 2'd2;

  // input tdata layout, lowest field first
  localparam int IN_SLOT_LSB   = 0;
  localparam int IN_START_LSB  = IN_SLOT_LSB + SLOT_W;
  localparam int IN_MSIZE_LSB  = IN_START_LSB + ADDR_W;
  localparam int IN_FOFF_LSB   = IN_MSIZE_LSB + ADDR_W;
  localparam int IN_FSIZE_LSB  = IN_FOFF_LSB + ADDR_W;
  localparam int IN_QUERY_LSB  = IN_FSIZE_LSB + ADDR_W;
  localparam int IN_USED_W     = IN_QUERY_LSB + ADDR_W;
  localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout, lowest field first
  localparam int OUT_SLOT_LSB  = ADDR_W;
  localparam int OUT_USED_W    = ADDR_W + SLOT_W;
  localparam int OUT_TDATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] mem_size;
    logic [ADDR_W-1:0] file_offset;
    logic [ADDR_W-1:0] file_len;
  } seg_t;

  // per-lane control from the pipeline sequencer
  typedef struct packed {
    logic wr_en;    // load the lane's segment entry
    logic to_file;  // direction of the item entering stage 2
    logic ld2;      // stage 1 -> stage 2 advance
    logic ld3;      // stage 2 -> stage 3 advance
  } lane_ctl_t;

endpackage

`default_nettype wire

FILE: src/sat_lane.sv
// ----------------------------------------------------------------------------
// sat_lane
// One segment slot: holds the entry and runs its range check and
// translation in two register stages (subtract, then compare and add).
// ----------------------------------------------------------------------------
`default_nettype none

module sat_lane (
  input  wire                       clk,
  input  wire sat_pkg::lane_ctl_t   ctl,
  input  wire sat_pkg::seg_t        wr_seg,
  input  wire [sat_pkg::ADDR_W-1:0] query,
  output logic                      hit,
  output logic [sat_pkg::ADDR_W-1:0] result
);
  import sat_pkg::*;

  seg_t              seg_r;
  logic [ADDR_W-1:0] diff_r, size_r, other_r;
  logic [ADDR_W-1:0] diff_nxt, size_nxt, other_nxt;
  logic              hit_r;
  logic [ADDR_W-1:0] res_r;

  // pick the range base, size and target base for the direction
  always_comb begin
    if (ctl.to_file) begin
      diff_nxt  = query - seg_r.start;
      size_nxt  = seg_r.mem_size;
      other_nxt = seg_r.file_offset;
    end else begin
      diff_nxt  = query - seg_r.file_offset;
      size_nxt  = seg_r.file_len;
      other_nxt = seg_r.start;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      seg_r <= wr_seg;
    end
    if (ctl.ld2) begin
      diff_r  <= diff_nxt;
      size_r  <= size_nxt;
      other_r <= other_nxt;
    end
    if (ctl.ld3) begin
      hit_r <= (diff_r < size_r);
      res_r <= diff_r + other_r;
    end
  end

  assign hit    = hit_r;
  assign result = res_r;

endmodule

`default_nettype wire

FILE: src/segment_address_translation_core.sv
// ----------------------------------------------------------------------------
// segment_address_translation_core
// Segment table with virtual-address / file-offset translation.
// ----------------------------------------------------------------------------
// A translate transaction passes through stage 1 input, stage 2 subtract,
// stage 3 range compare and add and the output register before its result
// shows on out_*, and one transaction is taken every cycle while the
// output side keeps up; each slot has its own subtract, compare and add, so
// all slots are checked in parallel and the lowest active hitting slot
// wins. A write transaction loads its slot at the accepting edge and gives
// no result; operation 3 is dropped. The table holds MAX_SEGMENTS slots, at
// most eight, since the slot field is three bits wide. Configuration writes
// are always ready and take effect at the next edge; change them only while
// no translation is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_address_translation_core #(
  parameter int MAX_SEGMENTS = sat_pkg::MAX_SEGMENTS_DEF
) (
  input  wire                            clk,
  input  wire                            rst_n,
  // in_tdata: slot, segment start, memory size, file offset, file size,
  //           query value, zero fill
  input  wire                            in_tvalid,
  output logic                           in_tready,
  input  wire [sat_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: operation
  input  wire [sat_pkg::OP_W-1:0]        in_tuser,
  // out_tdata: translated, hit_slot, zero fill
  output logic                           out_tvalid,
  input  wire                            out_tready,
  output logic [sat_pkg::OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: segment_hit
  output logic                           out_tuser,
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [sat_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [sat_pkg::ADDR_W-1:0]      cfg_data
);
  import sat_pkg::*;

  localparam int SLOTS     = 1 << SLOT_W;
  localparam int SEG_DEPTH = (MAX_SEGMENTS < SLOTS) ? MAX_SEGMENTS : SLOTS;

  // configuration
  logic              elf_mode_r;
  logic [ADDR_W-1:0] load_bias_r;
  logic [CNT_W-1:0]  seg_count_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elf_mode_r  <= 1'b0;
      load_bias_r <= '0;
      seg_count_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ELF_MODE:  elf_mode_r  <= cfg_data[0];
        CFG_LOAD_BIAS: load_bias_r <= cfg_data;
        CFG_SEG_COUNT: seg_count_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic [SLOT_W-1:0] in_slot;
  logic [ADDR_W-1:0] in_query;
  seg_t              in_seg;
  logic              in_acc;
  logic              in_xlate;

  assign in_slot            = in_tdata[IN_SLOT_LSB +: SLOT_W];
  assign in_seg.start       = in_tdata[IN_START_LSB +: ADDR_W];
  assign in_seg.mem_size    = in_tdata[IN_MSIZE_LSB +: ADDR_W];
  assign in_seg.file_offset = in_tdata[IN_FOFF_LSB +: ADDR_W];
  assign in_seg.file_len    = in_tdata[IN_FSIZE_LSB +: ADDR_W];
  assign in_query           = in_tdata[IN_QUERY_LSB +: ADDR_W];
  assign in_acc             = in_tvalid && in_tready;
  assign in_xlate           = (in_tuser == OP_TO_FILE) || (in_tuser == OP_TO_VIRT);

  // pipeline valids and ready chain
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic adv1, adv2, adv3;

  assign rdy_out   = !out_valid_r || out_tready;
  assign adv3      = v3_r && rdy_out;
  assign rdy3      = !v3_r || rdy_out;
  assign adv2      = v2_r && rdy3;
  assign rdy2      = !v2_r || rdy3;
  assign adv1      = v1_r && rdy2;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_acc && in_xlate;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy_out) out_valid_r <= v3_r;
    end
  end

  // stage payloads
  logic                 to_file1_r;
  logic [ADDR_W-1:0]    q1_r;
  logic [ADDR_W-1:0]    fb2_r, fb3_r;
  logic [ADDR_W-1:0]    fb_nxt;
  logic [SEG_DEPTH-1:0] act_nxt, act2_r, act3_r;

  assign fb_nxt = to_file1_r ? (q1_r - load_bias_r) : (q1_r + load_bias_r);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      to_file1_r <= (in_tuser == OP_TO_FILE);
      q1_r       <= in_query;
    end
    if (adv1) begin
      fb2_r  <= fb_nxt;
      act2_r <= act_nxt;
    end
    if (adv2) begin
      fb3_r  <= fb2_r;
      act3_r <= act2_r;
    end
  end

  // segment lanes
  logic [SEG_DEPTH-1:0] lane_hit;
  logic [ADDR_W-1:0]    lane_res [SEG_DEPTH];

  for (genvar gi = 0; gi < SEG_DEPTH; gi++) begin : g_lane
    lane_ctl_t ctl;

    assign ctl.wr_en   = in_acc && (in_tuser == OP_WRITE) && (in_slot == SLOT_W'(gi));
    assign ctl.to_file = to_file1_r;
    assign ctl.ld2     = adv1;
    assign ctl.ld3     = adv2;
    assign act_nxt[gi] = !elf_mode_r && (CNT_W'(gi) < seg_count_r);

    sat_lane u_lane (
      .clk    (clk),
      .ctl    (ctl),
      .wr_seg (in_seg),
      .query  (q1_r),
      .hit    (lane_hit[gi]),
      .result (lane_res[gi])
    );
  end

  // lowest active hitting lane wins
  logic              sel_hit;
  logic [SLOT_W-1:0] sel_slot;
  logic [ADDR_W-1:0] sel_res;

  always_comb begin
    sel_hit  = 1'b0;
    sel_slot = '0;
    sel_res  = fb3_r;
    for (int i = SEG_DEPTH - 1; i >= 0; i--) begin
      if (lane_hit[i] && act3_r[i]) begin
        sel_hit  = 1'b1;
        sel_slot = SLOT_W'(i);
        sel_res  = lane_res[i];
      end
    end
  end

  logic [ADDR_W-1:0] out_trans_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic              out_hit_r;

  always_ff @(posedge clk) begin
    if (adv3) begin
      out_trans_r <= sel_res;
      out_slot_r  <= sel_slot;
      out_hit_r   <= sel_hit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_slot_r, out_trans_r};

endmodule

`default_nettype wire

FILE: src/sat_checker.sv
// ----------------------------------------------------------------------------
// sat_checker
// Port-level checks of the segment address translation core.
// ----------------------------------------------------------------------------
`include "segment_address_translation_core_macros.svh"

`default_nettype none

module sat_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [sat_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input wire                             out_tuser
);
  import sat_pkg::*;

  // a fallback result carries slot zero
  `SAT_ASSERT_IMP(a_miss_slot_zero, out_tvalid && !out_tuser, out_tdata[OUT_SLOT_LSB +: SLOT_W] == '0, "hit_slot not zero on fallback result")

  // a free output side lets the whole pipeline advance
  `SAT_ASSERT_IMP(a_ready_chain, out_tready, in_tready, "in_tready low while out_tready high")

  // a stalled result holds
  `SAT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // reset empties the output
  `SAT_ASSERT_RST(a_rst_empty, !out_tvalid, "out_tvalid high after reset")

endmodule

bind segment_address_translation_core sat_checker u_sat_checker (.*);

`default_nettype wire
